@@ rtl/core/firmware_image_stream_checker_unit_assert.svh @@
// Assertion macros for the firmware image stream checker.
// Used by the checker module; expects clk_i and rst_ni in scope.
`ifndef FIRMWARE_IMAGE_STREAM_CHECKER_UNIT_ASSERT_SVH
`define FIRMWARE_IMAGE_STREAM_CHECKER_UNIT_ASSERT_SVH

// same-cycle implication
`define FISC_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fisc assertion failed");

// next-cycle implication
`define FISC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fisc assertion failed");

`endif

@@ rtl/core/fisc_pkg.sv @@
// Shared types, constants and the CRC byte step for the image stream checker.
// No dependencies.
`default_nettype none

package fisc_pkg;

  localparam int unsigned SizeBits = 20;
  localparam int unsigned OutSizeW = 20;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [SizeBits-1:0] CountTop = {SizeBits{1'b1}};
  localparam logic [31:0]         CrcPoly  = 32'hEDB8_8320;
  localparam logic [31:0]         CrcInit  = 32'hFFFF_FFFF;

  localparam logic [31:0]         AppBaseRst = 32'h0801_0000;
  localparam logic [OutSizeW-1:0] MaxSizeRst = OutSizeW'(448 * 1024);
  localparam logic [OutSizeW-1:0] MinSizeRst = OutSizeW'(512);
  localparam logic [31:0]         RamLowRst  = 32'h2000_0000;
  localparam logic [31:0]         RamHighRst = 32'h2002_0000;

  localparam logic [CfgIdxW-1:0] RegAppBase = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMaxSize = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMinSize = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRamLow  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRamHigh = 3'd4;

  localparam logic [1:0] StatusOk     = 2'd0;
  localparam logic [1:0] StatusSize   = 2'd1;
  localparam logic [1:0] StatusVector = 2'd2;

  typedef struct packed {
    logic [31:0]         app_base;
    logic [OutSizeW-1:0] max_size;
    logic [OutSizeW-1:0] min_size;
    logic [31:0]         ram_low;
    logic [31:0]         ram_high;
  } fisc_cfg_t;

  typedef struct packed {
    logic [31:0]         word;
    logic [OutSizeW-1:0] offset;
    logic                final_item;
    logic [SizeBits-1:0] size;
    logic                size_over;
    logic [31:0]         crc;
    logic [31:0]         stack_word;
    logic [31:0]         entry_word;
  } fisc_job_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CrcPoly : 32'h0);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/fisc_front.sv @@
// Front part: takes bytes, runs CRC, count, word packing and vector capture.
// Depends on fisc_pkg; pushes one job per emitted word into the queue.
`default_nettype none

module fisc_front import fisc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic      last_byte_i,
  output logic      push_valid_o,
  output fisc_job_t push_job_o,
  input  logic      push_ready_i
);

  logic [31:0]         crc_q, crc_d;
  logic [SizeBits-1:0] count_q, count_d;
  logic [23:0]         pending_q, pending_d;
  logic [31:0]         stack_q, stack_d;
  logic [31:0]         entry_q, entry_d;
  logic                over_q, over_d;

  logic                accept;
  logic [1:0]          lane;
  logic                at_top;
  logic                emit;
  logic [31:0]         crc_next;
  logic [SizeBits-1:0] count_next;
  logic                over_next;
  logic [31:0]         stack_next, entry_next;
  logic [31:0]         pend_w;
  logic [31:0]         word;
  logic [4:0]          sh;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i & in_ready_o;
  assign lane       = count_q[1:0];
  assign sh         = {lane, 3'b000};
  assign at_top     = (count_q == CountTop);
  assign emit       = (lane == 2'd3) | last_byte_i;
  assign crc_next   = crc_byte(crc_q, data_byte_i);
  assign count_next = at_top ? count_q : count_q + SizeBits'(1);
  assign over_next  = over_q | at_top;
  assign pend_w     = {8'h00, pending_q};

  always_comb begin
    stack_next = stack_q;
    entry_next = entry_q;
    if (count_q[SizeBits-1:2] == '0) begin
      stack_next = stack_q | ({24'h0, data_byte_i} << sh);
    end else if (count_q[SizeBits-1:3] == '0) begin
      entry_next = entry_q | ({24'h0, data_byte_i} << sh);
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (2'(i) < lane) begin
        word[8*i +: 8] = pend_w[8*i +: 8];
      end else if (2'(i) == lane) begin
        word[8*i +: 8] = data_byte_i;
      end else begin
        word[8*i +: 8] = 8'hFF;
      end
    end
  end

  always_comb begin
    push_job_o.word       = word;
    push_job_o.offset     = OutSizeW'({count_q[SizeBits-1:2], 2'b00});
    push_job_o.final_item = last_byte_i;
    push_job_o.size       = count_next;
    push_job_o.size_over  = over_next;
    push_job_o.crc        = ~crc_next;
    push_job_o.stack_word = stack_next;
    push_job_o.entry_word = entry_next;
  end

  assign push_valid_o = in_valid_i & emit;

  always_comb begin
    crc_d     = crc_q;
    count_d   = count_q;
    pending_d = pending_q;
    stack_d   = stack_q;
    entry_d   = entry_q;
    over_d    = over_q;
    if (accept) begin
      if (emit && last_byte_i) begin
        crc_d     = CrcInit;
        count_d   = '0;
        pending_d = '0;
        stack_d   = '0;
        entry_d   = '0;
        over_d    = 1'b0;
      end else begin
        crc_d   = crc_next;
        count_d = count_next;
        stack_d = stack_next;
        entry_d = entry_next;
        over_d  = over_next;
        if (emit) begin
          pending_d = '0;
        end else begin
          for (int i = 0; i < 3; i++) begin
            if (lane == 2'(i)) begin
              pending_d[8*i +: 8] = data_byte_i;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q     <= CrcInit;
      count_q   <= '0;
      pending_q <= '0;
      stack_q   <= '0;
      entry_q   <= '0;
      over_q    <= 1'b0;
    end else begin
      crc_q     <= crc_d;
      count_q   <= count_d;
      pending_q <= pending_d;
      stack_q   <= stack_d;
      entry_q   <= entry_d;
      over_q    <= over_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/fisc_queue.sv @@
// Two-entry job queue between the front and back parts.
// Depends on fisc_pkg for the job type.
`default_nettype none

module fisc_queue import fisc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  output logic      push_ready_o,
  input  fisc_job_t push_job_i,
  output logic      pop_valid_o,
  input  logic      pop_ready_i,
  output fisc_job_t pop_job_o
);

  fisc_job_t  slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       push, pop;

  assign push_ready_o = (fill_q != 2'd2);
  assign pop_valid_o  = (fill_q != 2'd0);
  assign pop_job_o    = slot_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/fisc_back.sv @@
// Back part: forms the verdict from a queued job and holds the result register.
// Depends on fisc_pkg; reads the configuration registers.
`default_nettype none

module fisc_back import fisc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fisc_cfg_t           cfg_i,
  input  logic                pop_valid_i,
  output logic                pop_ready_o,
  input  fisc_job_t           pop_job_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [31:0]         program_word_o,
  output logic [OutSizeW-1:0] word_offset_o,
  output logic                is_final_o,
  output logic [1:0]          status_o,
  output logic [31:0]         image_crc_o,
  output logic [OutSizeW-1:0] image_size_o
);

  logic                valid_q, valid_d;
  logic [31:0]         word_q;
  logic [OutSizeW-1:0] offset_q;
  logic                final_q;
  logic [1:0]          status_q, status_d;
  logic [31:0]         crc_q;
  logic [OutSizeW-1:0] size_q;
  logic                load;
  logic [31:0]         size32;
  logic [32:0]         limit;

  assign pop_ready_o = ~valid_q | out_ready_i;
  assign load        = pop_valid_i & pop_ready_o;
  assign size32      = 32'(pop_job_i.size);
  assign limit       = {1'b0, cfg_i.app_base} + 33'(pop_job_i.size);

  always_comb begin
    priority if (pop_job_i.size_over ||
                 size32 < 32'(cfg_i.min_size) || size32 > 32'(cfg_i.max_size)) begin
      status_d = StatusSize;
    end else if (pop_job_i.stack_word < cfg_i.ram_low ||
                 pop_job_i.stack_word > cfg_i.ram_high ||
                 pop_job_i.entry_word < cfg_i.app_base ||
                 {1'b0, pop_job_i.entry_word} >= limit) begin
      status_d = StatusVector;
    end else begin
      status_d = StatusOk;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q   <= pop_job_i.word;
      offset_q <= pop_job_i.offset;
      final_q  <= pop_job_i.final_item;
      status_q <= pop_job_i.final_item ? status_d : StatusOk;
      crc_q    <= pop_job_i.final_item ? pop_job_i.crc : 32'h0;
      size_q   <= pop_job_i.final_item ? OutSizeW'(pop_job_i.size) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign out_valid_o    = valid_q;
  assign program_word_o = word_q;
  assign word_offset_o  = offset_q;
  assign is_final_o     = final_q;
  assign status_o       = status_q;
  assign image_crc_o    = crc_q;
  assign image_size_o   = size_q;

endmodule

`default_nettype wire

@@ rtl/core/firmware_image_stream_checker_unit.sv @@
// Top level of the firmware image stream checker: config registers, front, queue, back.
// Depends on fisc_pkg, fisc_front, fisc_queue and fisc_back.
//
//   channel | handshake               | payload
//   --------+-------------------------+---------------------------------------------
//   in      | in_valid_i / in_ready_o | data_byte_i, last_byte_i
//   out     | out_valid_o/out_ready_i | program_word_o, word_offset_o, is_final_o,
//           |                         | status_o, image_crc_o, image_size_o
//   cfg     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One byte per cycle while the queue has room; the byte CRC step and count update finish in
// the cycle of acceptance. Each result goes through a queue slot into the result register.
// A two-entry queue decouples byte intake from the result register, so intake stalls
// only when the queue is full. Reset loads the register defaults and clears stream state.
`default_nettype none

module firmware_image_stream_checker_unit import fisc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          data_byte_i,
  input  logic                last_byte_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [31:0]         program_word_o,
  output logic [OutSizeW-1:0] word_offset_o,
  output logic                is_final_o,
  output logic [1:0]          status_o,
  output logic [31:0]         image_crc_o,
  output logic [OutSizeW-1:0] image_size_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  fisc_cfg_t cfg_q, cfg_d;
  logic      push_valid, push_ready;
  fisc_job_t push_job;
  logic      pop_valid, pop_ready;
  fisc_job_t pop_job;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegAppBase: cfg_d.app_base = cfg_data_i;
        RegMaxSize: cfg_d.max_size = cfg_data_i[OutSizeW-1:0];
        RegMinSize: cfg_d.min_size = cfg_data_i[OutSizeW-1:0];
        RegRamLow:  cfg_d.ram_low  = cfg_data_i;
        RegRamHigh: cfg_d.ram_high = cfg_data_i;
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.app_base <= AppBaseRst;
      cfg_q.max_size <= MaxSizeRst;
      cfg_q.min_size <= MinSizeRst;
      cfg_q.ram_low  <= RamLowRst;
      cfg_q.ram_high <= RamHighRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  fisc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .push_valid_o (push_valid),
    .push_job_o   (push_job),
    .push_ready_i (push_ready)
  );

  fisc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job)
  );

  fisc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .pop_job_i      (pop_job),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .program_word_o (program_word_o),
    .word_offset_o  (word_offset_o),
    .is_final_o     (is_final_o),
    .status_o       (status_o),
    .image_crc_o    (image_crc_o),
    .image_size_o   (image_size_o)
  );

endmodule

`default_nettype wire

@@ rtl/core/fisc_checker.sv @@
// Port-level checks for the firmware image stream checker, bound to the top level.
// Depends on fisc_pkg and firmware_image_stream_checker_unit_assert.svh.
`default_nettype none
`include "firmware_image_stream_checker_unit_assert.svh"

module fisc_checker import fisc_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [31:0]         program_word_o,
  input logic [OutSizeW-1:0] word_offset_o,
  input logic                is_final_o,
  input logic [1:0]          status_o,
  input logic [31:0]         image_crc_o,
  input logic [OutSizeW-1:0] image_size_o
);

  `FISC_ASSERT_IMPLY(a_word_aligned, out_valid_o, word_offset_o[1:0] == 2'b00)
  `FISC_ASSERT_IMPLY(a_plain_word_clean, out_valid_o && !is_final_o,
                     status_o == StatusOk && image_crc_o == 32'h0 && image_size_o == '0)
  `FISC_ASSERT_IMPLY(a_status_known, out_valid_o,
                     status_o == StatusOk || status_o == StatusSize || status_o == StatusVector)
  `FISC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
                    out_valid_o && $stable(program_word_o) && $stable(image_crc_o))

endmodule

bind firmware_image_stream_checker_unit fisc_checker u_fisc_checker (.*);

`default_nettype wire

@@ verif/tb_firmware_image_stream_checker_unit.sv @@
// Testbench for firmware_image_stream_checker_unit: streams firmware images byte by byte
// and checks every program word and verdict against a local CRC-32 / vector-table predictor.
// Depends on fisc_pkg and the RTL of the unit; needs no other file.

module tb_firmware_image_stream_checker_unit;
  import fisc_pkg::*;

  localparam int LimitCycles  = 4_000_000;
  localparam int SettleCycles = 8;
  localparam int PhaseCount   = 4;
  localparam int PhaseItems   = 50;
  localparam int QueueDepth   = 64;

  localparam logic [31:0] CrcReflPoly = 32'hEDB8_8320;
  localparam logic [31:0] DefAppBase  = 32'h0801_0000;
  localparam logic [19:0] DefMaxSize  = 20'd458752;
  localparam logic [19:0] DefMinSize  = 20'd512;
  localparam logic [31:0] DefRamLow   = 32'h2000_0000;
  localparam logic [31:0] DefRamHigh  = 32'h2002_0000;
  localparam logic [19:0] CountMax    = 20'hF_FFFF;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } image_byte_t;

  typedef struct packed {
    logic [31:0]         word;
    logic [OutSizeW-1:0] offset;
    logic                fin;
    logic [1:0]          status;
    logic [31:0]         crc;
    logic [OutSizeW-1:0] size;
  } word_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [7:0]          data_byte = 8'h00;
  logic                last_byte = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [31:0]         program_word;
  logic [OutSizeW-1:0] word_offset;
  logic                is_final;
  logic [1:0]          status;
  logic [31:0]         image_crc;
  logic [OutSizeW-1:0] image_size;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  firmware_image_stream_checker_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .data_byte_i    (data_byte),
    .last_byte_i    (last_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .program_word_o (program_word),
    .word_offset_o  (word_offset),
    .is_final_o     (is_final),
    .status_o       (status),
    .image_crc_o    (image_crc),
    .image_size_o   (image_size),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  // predictor state
  logic [31:0] app_base = DefAppBase;
  logic [19:0] max_size = DefMaxSize;
  logic [19:0] min_size = DefMinSize;
  logic [31:0] ram_low  = DefRamLow;
  logic [31:0] ram_high = DefRamHigh;

  logic [31:0] crc_acc    = 32'hFFFF_FFFF;
  logic [19:0] byte_cnt   = '0;
  logic [23:0] lane_bytes = '0;
  logic [31:0] sp_word    = '0;
  logic [31:0] rv_word    = '0;
  logic        cnt_over   = 1'b0;

  image_byte_t  image_bytes[$];
  word_result_t expected_words[$];

  int cycle_cnt  = 0;
  int err_cnt    = 0;
  bit byte_taken = 1'b0;
  bit steady     = 1'b0;
  int burst_left = 0;
  int gap_left   = 0;
  int stall_left = 0;
  logic [15:0] stall_pat = '0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [31:0] crc32_next(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] r;
    logic        fb;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r = {1'b0, r[31:1]} ^ (fb ? CrcReflPoly : 32'h0);
    end
    return r;
  endfunction

  function automatic void clear_image();
    crc_acc    = 32'hFFFF_FFFF;
    byte_cnt   = '0;
    lane_bytes = '0;
    sp_word    = '0;
    rv_word    = '0;
    cnt_over   = 1'b0;
  endfunction

  function automatic void set_register(input logic [CfgIdxW-1:0] idx, input logic [31:0] v);
    case (idx)
      RegAppBase: app_base = v;
      RegMaxSize: max_size = v[19:0];
      RegMinSize: min_size = v[19:0];
      RegRamLow:  ram_low = v;
      RegRamHigh: ram_high = v;
      default: ;
    endcase
  endfunction

  function automatic void absorb_byte(input logic [7:0] b, input logic last);
    logic [19:0]  pos;
    logic [1:0]   lane;
    logic [31:0]  w;
    logic [32:0]  limit;
    logic [19:0]  sz;
    word_result_t r;
    pos  = byte_cnt;
    lane = pos[1:0];
    crc_acc = crc32_next(crc_acc, b);
    if (pos < 4) sp_word[8*lane +: 8] = b;
    else if (pos < 8) rv_word[8*lane +: 8] = b;
    if (pos == CountMax) cnt_over = 1'b1;
    else byte_cnt = pos + 20'd1;

    if (lane != 2'd3 && !last) begin
      lane_bytes[8*lane +: 8] = b;
    end else begin
      w = 32'hFFFF_FFFF;
      for (int k = 0; k < 3; k++) begin
        if (k < lane) w[8*k +: 8] = lane_bytes[8*k +: 8];
      end
      w[8*lane +: 8] = b;
      r.word   = w;
      r.offset = {pos[19:2], 2'b00};
      if (!last) begin
        lane_bytes = '0;
        r.fin    = 1'b0;
        r.status = StatusOk;
        r.crc    = '0;
        r.size   = '0;
      end else begin
        sz    = byte_cnt;
        limit = {1'b0, app_base} + {13'b0, sz};
        r.fin = 1'b1;
        if (cnt_over || sz < min_size || sz > max_size) r.status = StatusSize;
        else if (sp_word < ram_low || sp_word > ram_high || rv_word < app_base ||
                 {1'b0, rv_word} >= limit) r.status = StatusVector;
        else r.status = StatusOk;
        r.crc  = ~crc_acc;
        r.size = sz;
        clear_image();
      end
      expected_words.push_back(r);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_cnt++;
    $display("mismatch %s at cycle %0d: got %h want %h", what, cycle_cnt, got, want);
  endtask

  // byte driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid || byte_taken) begin
        byte_taken = 1'b0;
        if (!steady && gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (image_bytes.size() > 0) begin
          image_byte_t nb;
          nb = image_bytes.pop_front();
          data_byte <= nb.data;
          last_byte <= nb.last;
          in_valid  <= 1'b1;
          if (burst_left > 0) burst_left--;
          else begin
            gap_left   = $urandom_range(0, 6);
            burst_left = ($urandom_range(0, 4) == 0) ? 200 : $urandom_range(1, 24);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result receiver
  always @(negedge clk_i) begin
    if (steady) begin
      out_ready <= 1'b1;
    end else begin
      if (stall_left == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pat = 16'h0000;
          1: stall_pat = 16'($urandom);
          2: stall_pat = 16'hFFF0;
          default: stall_pat = 16'h5555;
        endcase
        stall_left = $urandom_range(16, 64);
      end
      stall_left--;
      out_ready <= ~stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[15:1]};
    end
  end

  // monitor: predicts on accepted bytes, checks accepted results
  always @(posedge clk_i) begin
    word_result_t e;
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        absorb_byte(data_byte, last_byte);
        byte_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", program_word, 32'h0);
        end else begin
          e = expected_words.pop_front();
          if (program_word !== e.word) report_mismatch("program_word", program_word, e.word);
          if (word_offset !== e.offset)
            report_mismatch("word_offset", 32'(word_offset), 32'(e.offset));
          if (is_final !== e.fin) report_mismatch("is_final", 32'(is_final), 32'(e.fin));
          if (status !== e.status) report_mismatch("status", 32'(status), 32'(e.status));
          if (image_crc !== e.crc) report_mismatch("image_crc", image_crc, e.crc);
          if (image_size !== e.size)
            report_mismatch("image_size", 32'(image_size), 32'(e.size));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= LimitCycles) begin
      $display("tb_firmware_image_stream_checker_unit: errors");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic last);
    image_byte_t nb;
    while (image_bytes.size() >= QueueDepth) @(posedge clk_i);
    nb.data = b;
    nb.last = last;
    image_bytes.push_back(nb);
  endtask

  task automatic send_image(input int n, input logic [31:0] sp, input logic [31:0] rv);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      if (i < 4) b = sp[8*i +: 8];
      else if (i < 8) b = rv[8*(i-4) +: 8];
      else b = 8'($urandom);
      push_byte(b, i == n - 1);
    end
  endtask

  task automatic wait_idle();
    while (image_bytes.size() != 0 || in_valid || expected_words.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] v);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    set_register(idx, v);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_in(input logic [31:0] lo, input logic [31:0] hi);
    logic [32:0] span;
    logic [31:0] r;
    span = {1'b0, hi} - {1'b0, lo} + 33'd1;
    r = $urandom;
    case ($urandom_range(0, 3))
      0: return lo;
      1: return hi;
      default: return span[32] ? r : lo + (r % span[31:0]);
    endcase
  endfunction

  task automatic apply_settings(input int p);
    logic [31:0] a, lo, hi, junk;
    logic [19:0] mn, mx;
    junk = $urandom;
    case (p)
      0: begin
        a = 32'h0; mn = 20'd8; mx = CountMax; lo = 32'h0; hi = 32'hFFFF_FFFF;
      end
      1: begin
        a = 32'hFFFF_FFFF; mn = CountMax; mx = CountMax; lo = 32'hFFFF_FFFF; hi = 32'h0;
      end
      2: begin
        a = $urandom; mn = 20'd8; mx = 20'd0; lo = $urandom; hi = 32'hFFFF_FFFF;
      end
      default: begin
        if ($urandom_range(0, 5) == 0) a = $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
        else a = $urandom;
        mn = 20'($urandom_range(8, 24));
        mx = 20'($urandom_range(12, 64));
        lo = $urandom;
        case ($urandom_range(0, 3))
          0: hi = lo;
          1: hi = lo - 32'd1;
          default: hi = (lo > 32'hFFF0_0000) ? 32'hFFFF_FFFF : lo + $urandom_range(0, 32'hF_FFFF);
        endcase
      end
    endcase
    write_reg(RegAppBase, a);
    write_reg(RegMaxSize, {junk[31:20], mx});
    write_reg(RegMinSize, {junk[19:8], mn});
    write_reg(RegRamLow, lo);
    write_reg(RegRamHigh, hi);
  endtask

  task automatic random_image(output int n);
    logic [31:0] sp, rv, rv_hi;
    logic [32:0] top;
    int          pick;
    pick = $urandom_range(0, 19);
    if (pick < 12) n = $urandom_range(1, 40);
    else if (pick < 18) n = $urandom_range(41, 100);
    else n = $urandom_range(1, 8);
    top   = {1'b0, app_base} + 33'(n) - 33'd1;
    rv_hi = top[32] ? 32'hFFFF_FFFF : top[31:0];
    sp = (ram_low <= ram_high) ? pick_in(ram_low, ram_high) : $urandom;
    rv = pick_in(app_base, rv_hi);
    case ($urandom_range(0, 9))
      7: begin
        sp = $urandom;
        rv = $urandom;
      end
      8: begin
        if (ram_high != 32'hFFFF_FFFF) sp = ram_high + 32'd1;
        else if (ram_low != 32'h0) sp = ram_low - 32'd1;
      end
      9: rv = $urandom_range(0, 1) ? app_base + 32'(n) : app_base - 32'd1;
      default: ;
    endcase
    send_image(n, sp, rv);
  endtask

  initial begin
    int n, sent;
    clear_image();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // short images under reset settings: tail on every lane, vectors cut short
    send_image(1, 32'h2000_1000, 32'h0801_0100);
    send_image(3, 32'hFFFF_FFFF, 32'h0);
    send_image(4, 32'h0, 32'hFFFF_FFFF);
    send_image(6, 32'h2002_0000, 32'h0801_0000);
    send_image(9, 32'h1FFF_FFFF, 32'h0801_0001);
    wait_idle();

    // minimum size, stack at top of window, entry at last byte of image, full rate
    steady = 1'b1;
    send_image(512, DefRamHigh, DefAppBase + 32'd511);
    wait_idle();
    steady = 1'b0;

    for (int p = 0; p < PhaseCount; p++) begin
      apply_settings(p);
      if (p == 0) begin
        for (int k = int'(RegRamHigh) + 1; k < (1 << CfgIdxW); k++)
          write_reg(CfgIdxW'(k), $urandom);
      end
      sent = 0;
      while (sent < PhaseItems) begin
        random_image(n);
        sent += n;
      end
      wait_idle();
    end

    if (err_cnt == 0) begin
      $display("tb_firmware_image_stream_checker_unit: clean");
    end else begin
      $display("tb_firmware_image_stream_checker_unit: errors");
    end
    $finish;
  end

endmodule
